/* rtl/u8sd_pkg.sv */
// ----------------------------------------------------------------------------
// u8sd_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8sd_pkg;

    localparam int unsigned FIFO_DEPTH_DEF = 2;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned AVAIL_W = 3;
    localparam int unsigned CP_W    = 21;
    localparam int unsigned USED_W  = 3;
    localparam int unsigned PEND_W  = 2;
    localparam int unsigned LEAD_W  = 7;

    localparam int unsigned S_TDATA_W = 16;
    localparam int unsigned M_TDATA_W = 32;

    localparam logic [USED_W-1:0] USED_ONE = USED_W'(1);

    // Lead classification of a byte, independent of decoder state
    typedef enum logic [2:0] {
        CLS_ASCII = 3'd0,
        CLS_LEAD2 = 3'd1,
        CLS_LEAD3 = 3'd2,
        CLS_LEAD4 = 3'd3,
        CLS_ERR   = 3'd4
    } cls_t;

    // One classified byte as held in the queue
    typedef struct packed {
        logic [BYTE_W-1:0] raw;      // original byte, used as continuation
        cls_t              cls;      // meaning when taken as a lead
        logic              short_av; // not enough bytes for this lead
        logic [LEAD_W-1:0] lead_val; // masked lead payload bits
        logic              cont_ok;  // byte lies in 0x80-0xBF
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

/* rtl/u8sd_front.sv */
// ----------------------------------------------------------------------------
// u8sd_front
// Input side: takes the byte stream and classifies each byte for the queue.
// ----------------------------------------------------------------------------
module u8sd_front (
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [u8sd_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                               push,
    output u8sd_pkg::entry_t                   push_entry,
    input  logic                               q_full
);

    logic [u8sd_pkg::BYTE_W-1:0]  b;
    logic [u8sd_pkg::AVAIL_W-1:0] avail;

    assign b        = s_tdata[u8sd_pkg::BYTE_W-1:0];
    assign avail    = s_tdata[u8sd_pkg::BYTE_W +: u8sd_pkg::AVAIL_W];
    assign s_tready = ~q_full;
    assign push     = s_tvalid & ~q_full;

    always_comb begin
        push_entry          = '0;
        push_entry.raw      = b;
        push_entry.cont_ok  = (b[7:6] == 2'b10);
        priority if (b[7] == 1'b0) begin
            push_entry.cls      = u8sd_pkg::CLS_ASCII;
            push_entry.short_av = (avail == 3'd0);
            push_entry.lead_val = b[6:0];
        end else if (b[6] == 1'b0 || b[7:3] == 5'b11111) begin
            push_entry.cls      = u8sd_pkg::CLS_ERR;
            push_entry.short_av = 1'b0;
        end else if (b[5] == 1'b0) begin
            push_entry.cls      = u8sd_pkg::CLS_LEAD2;
            push_entry.short_av = (avail < 3'd2);
            push_entry.lead_val = {2'b00, b[4:0]};
        end else if (b[4] == 1'b0) begin
            push_entry.cls      = u8sd_pkg::CLS_LEAD3;
            push_entry.short_av = (avail < 3'd3);
            push_entry.lead_val = {3'b000, b[3:0]};
        end else begin
            push_entry.cls      = u8sd_pkg::CLS_LEAD4;
            push_entry.short_av = (avail < 3'd4);
            push_entry.lead_val = {4'b0000, b[2:0]};
        end
    end

endmodule

/* rtl/u8sd_fifo.sv */
// ----------------------------------------------------------------------------
// u8sd_fifo
// Short register queue between the classifier and the sequence decoder.
// ----------------------------------------------------------------------------
module u8sd_fifo #(
    parameter int unsigned DEPTH = u8sd_pkg::FIFO_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  u8sd_pkg::entry_t  push_entry,
    output logic              full,
    input  logic              pop,
    output logic              q_valid,
    output u8sd_pkg::entry_t  q_entry
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    u8sd_pkg::entry_t  mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign q_valid = (count_reg != '0);
    assign q_entry = mem_reg[rd_ptr_reg];
    assign do_pop  = pop & q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (!push && do_pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* rtl/u8sd_back.sv */
// ----------------------------------------------------------------------------
// u8sd_back
// Sequence decoder: tracks open multi-byte sequences and registers results.
// ----------------------------------------------------------------------------
module u8sd_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               q_valid,
    input  u8sd_pkg::entry_t                   q_entry,
    output logic                               pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [u8sd_pkg::M_TDATA_W-1:0]     m_tdata
);

    logic [u8sd_pkg::PEND_W-1:0] pending_reg, pending_next;
    logic [u8sd_pkg::CP_W-1:0]   accum_reg, accum_next;
    logic [u8sd_pkg::USED_W-1:0] seq_len_reg, seq_len_next;
    logic                        bad_reg, bad_next;

    logic                        out_valid_reg, out_valid_next;
    logic [u8sd_pkg::CP_W-1:0]   cp_reg, cp_next;
    logic                        vres_reg, vres_next;
    logic [u8sd_pkg::USED_W-1:0] used_reg, used_next;

    logic                        emit;
    logic [u8sd_pkg::CP_W-1:0]   emit_cp;
    logic                        emit_ok;
    logic [u8sd_pkg::USED_W-1:0] emit_used;

    // Output register slot frees when its transaction completes
    assign pop = q_valid & (~out_valid_reg | m_tready);

    always_comb begin
        pending_next = pending_reg;
        accum_next   = accum_reg;
        seq_len_next = seq_len_reg;
        bad_next     = bad_reg;
        emit         = 1'b0;
        emit_cp      = '0;
        emit_ok      = 1'b0;
        emit_used    = u8sd_pkg::USED_ONE;
        if (pop) begin
            if (pending_reg != '0) begin
                accum_next   = {accum_reg[u8sd_pkg::CP_W-7:0], q_entry.raw[5:0]};
                bad_next     = bad_reg | ~q_entry.cont_ok;
                pending_next = pending_reg - u8sd_pkg::PEND_W'(1);
                if (pending_reg == u8sd_pkg::PEND_W'(1)) begin
                    emit      = 1'b1;
                    emit_ok   = ~bad_next;
                    emit_cp   = bad_next ? '0 : accum_next;
                    emit_used = seq_len_reg;
                end
            end else begin
                unique case (q_entry.cls)
                    u8sd_pkg::CLS_ASCII: begin
                        emit    = 1'b1;
                        emit_ok = ~q_entry.short_av;
                        emit_cp = q_entry.short_av ? '0
                                : {{(u8sd_pkg::CP_W-u8sd_pkg::LEAD_W){1'b0}}, q_entry.lead_val};
                    end
                    u8sd_pkg::CLS_LEAD2, u8sd_pkg::CLS_LEAD3, u8sd_pkg::CLS_LEAD4: begin
                        if (q_entry.short_av) begin
                            emit = 1'b1;
                        end else begin
                            accum_next = {{(u8sd_pkg::CP_W-u8sd_pkg::LEAD_W){1'b0}},
                                          q_entry.lead_val};
                            bad_next   = 1'b0;
                            // length is class code plus one; pending is one less
                            seq_len_next = {1'b0, q_entry.cls[1:0]} + u8sd_pkg::USED_W'(1);
                            pending_next = q_entry.cls[1:0];
                        end
                    end
                    default: begin
                        emit = 1'b1;
                    end
                endcase
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        cp_next        = cp_reg;
        vres_next      = vres_reg;
        used_next      = used_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (emit) begin
            out_valid_next = 1'b1;
            cp_next        = emit_cp;
            vres_next      = emit_ok;
            used_next      = emit_used;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg   <= '0;
            accum_reg     <= '0;
            seq_len_reg   <= '0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            pending_reg   <= pending_next;
            accum_reg     <= accum_next;
            seq_len_reg   <= seq_len_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cp_reg   <= cp_next;
        vres_reg <= vres_next;
        used_reg <= used_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(u8sd_pkg::M_TDATA_W-u8sd_pkg::CP_W-1-u8sd_pkg::USED_W){1'b0}},
                       used_reg, vres_reg, cp_reg};

endmodule

/* rtl/utf8_stream_decoder.sv */
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Byte-serial UTF-8 decoder, one byte per transaction, one result per char.
// Throughput: one byte per cycle while m_tready back-pressure does not stall the output.
// Path: each byte is registered in the queue, then its entry is decoded straight
// into the output register that drives m_tvalid and m_tdata.
// Reset: synchronous aresetn clears the queue, open sequence and output valid.
// ----------------------------------------------------------------------------
module utf8_stream_decoder #(
    parameter int unsigned FIFO_DEPTH = u8sd_pkg::FIFO_DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [7:0] in_byte, [10:8] bytes_available, [15:11] zero
    input  logic [u8sd_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [20:0] code_point, [21] valid_res, [24:22] bytes_used, [31:25] zero
    output logic [u8sd_pkg::M_TDATA_W-1:0]     m_tdata
);

    logic             push;
    u8sd_pkg::entry_t push_entry;
    logic             q_full;
    logic             pop;
    logic             q_valid;
    u8sd_pkg::entry_t q_entry;

    u8sd_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full)
    );

    u8sd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_entry    (q_entry)
    );

    u8sd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* tb/utf8_decode_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_decode_checker
// Watches both stream channels of the UTF-8 decoder. Every accepted input
// byte is run through a behavioral decoder. Each character or error it
// completes is queued. Each result transaction is compared field by field
// with the oldest queued entry.
// ----------------------------------------------------------------------------
module utf8_decode_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // [7:0] in_byte, [10:8] bytes_available, [15:11] zero
    input  logic [u8sd_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // [20:0] code_point, [21] valid_res, [24:22] bytes_used, [31:25] zero
    input  logic [u8sd_pkg::M_TDATA_W-1:0] m_tdata,
    output int                             fail_count,
    output int                             chars_waiting,
    output int                             results_checked,
    output int                             error_results
);

    localparam int unsigned PAD_W    = u8sd_pkg::M_TDATA_W - u8sd_pkg::CP_W - 1
                                       - u8sd_pkg::USED_W;
    localparam int unsigned MAX_SHOW = 40;

    typedef struct packed {
        logic [PAD_W-1:0]            pad;
        logic [u8sd_pkg::USED_W-1:0] used;
        logic                        ok;
        logic [u8sd_pkg::CP_W-1:0]   cp;
    } char_t;

    char_t pending_chars[$];

    // decoder state
    logic [u8sd_pkg::PEND_W-1:0] cont_left;
    logic [u8sd_pkg::CP_W-1:0]   cp_acc;
    logic [u8sd_pkg::USED_W-1:0] char_len;
    logic                        cont_err;

    task automatic report_mismatch(input string what, input int unsigned want_v,
                                   input int unsigned got_v);
        fail_count++;
        // keep the log bounded when the design is badly broken
        if (fail_count <= MAX_SHOW)
            $display("[%0t] MISMATCH %s: expected 0x%0h, got 0x%0h",
                     $time, what, want_v, got_v);
    endtask

    task automatic push_char(input logic [u8sd_pkg::CP_W-1:0] cp, input logic ok,
                             input logic [u8sd_pkg::USED_W-1:0] used);
        char_t c;
        c.pad  = '0;
        c.used = used;
        c.ok   = ok;
        c.cp   = ok ? cp : '0;
        pending_chars.push_back(c);
    endtask

    task automatic decode_byte(input logic [u8sd_pkg::BYTE_W-1:0] b,
                               input logic [u8sd_pkg::AVAIL_W-1:0] avail);
        u8sd_pkg::cls_t              cls;
        logic [u8sd_pkg::USED_W-1:0] len;
        logic [u8sd_pkg::CP_W-1:0]   lead_bits;
        if (cont_left != 0) begin
            // inside a sequence every byte is taken as a continuation
            cp_acc = {cp_acc[u8sd_pkg::CP_W-7:0], b[5:0]};
            if (b[7:6] != 2'b10)
                cont_err = 1'b1;
            cont_left = cont_left - 1'b1;
            if (cont_left == 0)
                push_char(cp_acc, !cont_err, char_len);
        end else begin
            if (b < 8'h80)
                cls = u8sd_pkg::CLS_ASCII;
            else if (b < 8'hc0 || b >= 8'hf8)
                cls = u8sd_pkg::CLS_ERR;
            else if (b < 8'he0)
                cls = u8sd_pkg::CLS_LEAD2;
            else if (b < 8'hf0)
                cls = u8sd_pkg::CLS_LEAD3;
            else
                cls = u8sd_pkg::CLS_LEAD4;
            lead_bits = '0;
            case (cls)
                u8sd_pkg::CLS_ASCII: begin
                    len = 3'd1;
                    lead_bits[6:0] = b[6:0];
                end
                u8sd_pkg::CLS_LEAD2: begin
                    len = 3'd2;
                    lead_bits[4:0] = b[4:0];
                end
                u8sd_pkg::CLS_LEAD3: begin
                    len = 3'd3;
                    lead_bits[3:0] = b[3:0];
                end
                u8sd_pkg::CLS_LEAD4: begin
                    len = 3'd4;
                    lead_bits[2:0] = b[2:0];
                end
                default: len = 3'd0;
            endcase
            // availability 0 also fails an ASCII byte
            if (cls == u8sd_pkg::CLS_ERR || avail < len)
                push_char('0, 1'b0, u8sd_pkg::USED_ONE);
            else if (cls == u8sd_pkg::CLS_ASCII)
                push_char(lead_bits, 1'b1, u8sd_pkg::USED_ONE);
            else begin
                char_len  = len;
                cont_left = u8sd_pkg::PEND_W'(len - 1);
                cp_acc    = lead_bits;
                cont_err  = 1'b0;
            end
        end
    endtask

    always @(posedge aclk) begin
        char_t want;
        char_t got;
        if (!aresetn) begin
            cont_left       = '0;
            cp_acc          = '0;
            char_len        = '0;
            cont_err        = 1'b0;
            fail_count      = 0;
            results_checked = 0;
            error_results   = 0;
            pending_chars.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                results_checked++;
                if (!got.ok)
                    error_results++;
                if (pending_chars.size() == 0) begin
                    report_mismatch("result with nothing pending", 0, m_tdata);
                end else begin
                    want = pending_chars.pop_front();
                    if (got.cp !== want.cp)
                        report_mismatch("code_point", 32'(want.cp), 32'(got.cp));
                    if (got.ok !== want.ok)
                        report_mismatch("valid_res", 32'(want.ok), 32'(got.ok));
                    if (got.used !== want.used)
                        report_mismatch("bytes_used", 32'(want.used), 32'(got.used));
                    if (got.pad !== want.pad)
                        report_mismatch("tdata padding", 32'(want.pad), 32'(got.pad));
                end
            end
            if (s_tvalid && s_tready)
                decode_byte(s_tdata[u8sd_pkg::BYTE_W-1:0],
                            s_tdata[u8sd_pkg::BYTE_W +: u8sd_pkg::AVAIL_W]);
        end
        chars_waiting <= pending_chars.size();
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for utf8_stream_decoder. A directed pass covers the byte range
// limits, stray and out-of-range leads, short streams and broken sequences.
// It is followed by random text: mostly well-formed characters of every
// length, mixed with short leads, broken sequences and noise bytes. Random
// gaps on the input and random back-pressure on the output.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int          BYTE_TARGET = 1375;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [u8sd_pkg::S_TDATA_W-1:0] s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [u8sd_pkg::M_TDATA_W-1:0] m_tdata;

    int fail_count;
    int chars_waiting;
    int results_checked;
    int error_results;

    int unsigned cycle_cnt = 0;
    int          bytes_sent = 0;
    int          no_gap_left = 0;

    always #5 aclk = ~aclk;

    utf8_stream_decoder i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    utf8_decode_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .chars_waiting   (chars_waiting),
        .results_checked (results_checked),
        .error_results   (error_results)
    );

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("utf8_stream_decoder test failed");
            $finish;
        end
    end

    // Lead byte of a sequence of the given length carrying the top bits of cp
    function automatic logic [7:0] lead_for(input int len,
                                            input logic [u8sd_pkg::CP_W-1:0] cp);
        case (len)
            1: return {1'b0, cp[6:0]};
            2: return {3'b110, cp[10:6]};
            3: return {4'b1110, cp[15:12]};
            default: return {5'b11110, cp[20:18]};
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b,
                             input logic [u8sd_pkg::AVAIL_W-1:0] av);
        int gap;
        int r;
        gap = 0;
        if (no_gap_left > 0) begin
            no_gap_left--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 5)
                no_gap_left = $urandom_range(20, 60);
            else if (r >= 62 && r < 94)
                gap = $urandom_range(1, 3);
            else if (r >= 94)
                gap = $urandom_range(8, 30);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(u8sd_pkg::S_TDATA_W - u8sd_pkg::AVAIL_W - u8sd_pkg::BYTE_W){1'b0}},
                     av, b};
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    // Well-formed character; availability on continuation bytes is random
    task automatic send_char(input int len, input logic [u8sd_pkg::CP_W-1:0] cp,
                             input logic [u8sd_pkg::AVAIL_W-1:0] av);
        send_byte(lead_for(len, cp), av);
        for (int i = len - 2; i >= 0; i--)
            send_byte({2'b10, cp[6*i +: 6]}, u8sd_pkg::AVAIL_W'($urandom_range(0, 7)));
    endtask

    // Output back-pressure: open stretches, short stalls and a few long ones
    initial begin
        int r;
        int n;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            r = $urandom_range(0, 99);
            if (r < 20) begin
                m_tready <= 1'b1;
                n = $urandom_range(20, 80);
            end else if (r < 60) begin
                m_tready <= 1'b1;
                n = $urandom_range(1, 4);
            end else if (r < 95) begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 3);
            end else begin
                m_tready <= 1'b0;
                n = $urandom_range(10, 30);
            end
            repeat (n) @(posedge aclk);
        end
    end

    initial begin
        int                          pick;
        int                          len;
        int                          bad_pos;
        logic [u8sd_pkg::CP_W-1:0]   cp;
        logic [7:0]                  b;
        int                          n_chars;
        int                          n_short;
        int                          n_broken;
        int                          n_noise;
        n_chars  = 0;
        n_short  = 0;
        n_broken = 0;
        n_noise  = 0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: limits, stray leads, short streams, bad continuations
        send_char(1, 21'h00, 3'd1);
        send_char(1, 21'h7f, 3'd4);
        send_byte(8'h41, 3'd0);             // ASCII with nothing available
        send_byte(8'h80, 3'd4);
        send_byte(8'hbf, 3'd7);
        send_byte(8'hf8, 3'd4);
        send_byte(8'hff, 3'd4);
        send_char(2, 21'h000, 3'd2);        // overlong C0 80 passes
        send_char(2, 21'h7ff, 3'd5);
        send_byte(8'he0, 3'd2);             // short stream, next byte is a lead
        send_byte(8'hf7, 3'd3);
        send_char(3, 21'hffff, 3'd3);
        send_char(4, 21'h1fffff, 3'd7);     // above 0x10FFFF still decodes
        send_byte(8'hc3, 3'd4);
        send_byte(8'h41, 3'd0);             // bad continuation
        send_byte(8'he2, 3'd6);
        send_byte(8'hff, 3'd1);
        send_byte(8'h80, 3'd0);

        while (bytes_sent < BYTE_TARGET) begin
            pick = $urandom_range(0, 99);
            len  = $urandom_range(1, 4);
            cp   = u8sd_pkg::CP_W'($urandom);
            if (pick < 65) begin
                send_char(len, cp, u8sd_pkg::AVAIL_W'($urandom_range(len, 7)));
                n_chars++;
            end else if (pick < 75) begin
                send_byte(lead_for(len, cp),
                          u8sd_pkg::AVAIL_W'($urandom_range(0, len - 1)));
                n_short++;
            end else if (pick < 87) begin
                len     = $urandom_range(2, 4);
                bad_pos = $urandom_range(1, len - 1);
                send_byte(lead_for(len, cp), u8sd_pkg::AVAIL_W'($urandom_range(len, 7)));
                for (int i = 1; i < len; i++) begin
                    b = 8'($urandom);
                    if (i == bad_pos && b[7:6] == 2'b10)
                        b[6] = 1'b1;
                    send_byte(b, u8sd_pkg::AVAIL_W'($urandom_range(0, 7)));
                end
                n_broken++;
            end else begin
                b = 8'($urandom);
                // bias half the noise toward stray leads
                if (pick < 94)
                    b = b[0] ? {2'b10, b[6:1]} : {5'b11111, b[3:1]};
                send_byte(b, u8sd_pkg::AVAIL_W'($urandom_range(0, 7)));
                n_noise++;
            end
        end
        s_tvalid <= 1'b0;

        do @(posedge aclk); while (chars_waiting != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Coverage: %0d bytes; %0d clean chars, %0d short leads,",
                 bytes_sent, n_chars, n_short);
        $display("  %0d broken seqs, %0d noise; %0d transactions checked, %0d errors",
                 n_broken, n_noise, results_checked, error_results);
        if (fail_count == 0)
            $display("utf8_stream_decoder test passed");
        else
            $display("utf8_stream_decoder test failed");
        $finish;
    end

endmodule
